@@ design/sensor_timestamp_aligner_core_assert.svh @@
// Assertion macros shared by the aligner RTL.
`ifndef SENSOR_TIMESTAMP_ALIGNER_CORE_ASSERT_SVH
`define SENSOR_TIMESTAMP_ALIGNER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define STA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define STA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sta_pkg.sv @@
package sta_pkg;

  localparam int unsigned TS_W  = 63;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned SEN_W = 3;

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_ALIGN = 2'd2;

  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_SKIPPED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] REG_MAX_DIFF    = 2'd0;
  localparam logic [1:0] REG_REQUIRE_ALL = 2'd1;
  localparam logic [1:0] REG_MAIN_SENSOR = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SEN_W-1:0] sensor;
    logic             has_timestamp;
    logic [TS_W-1:0]  timestamp;
    logic [11:0]      main_position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SEN_W-1:0]  matched_sensor;
    logic [IDX_W-1:0]  reference_index;
    logic [TS_W-1:0]   reference_timestamp;
    logic [IDX_W-1:0]  matched_index;
    logic [TS_W-1:0]   matched_timestamp;
    logic signed [63:0] ts_delta;
    logic              last;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_SRCH,   // binary search for the insertion point
    S_ADD_SRD,    // wait for search read data
    S_SHIFT_RD,   // read entry to move up by one
    S_SHIFT_WR,   // write moved entry
    S_ADD_WR,     // write the new entry
    S_ADD_OUT,
    S_AL_RREF,    // read reference entry
    S_AL_WREF,
    S_AL_NEXT,    // pick next present sensor
    S_AL_SRCH,
    S_AL_SRD,
    S_AL_RHI,     // read candidate at lo (lo-1 when lo is past the end)
    S_AL_WHI,
    S_AL_RLO,     // read candidate at lo-1 (lo when lo is zero)
    S_AL_WLO,
    S_AL_DEC,     // choose and check tolerance
    S_AL_PUT,     // not entered; matches are queued in S_AL_DEC
    S_AL_EMIT,    // drain the result buffer
    S_EMIT_WAIT
  } state_t;

endpackage

@@ design/sensor_timestamp_aligner_core.sv @@
// Sensor timestamp aligner. Open (cmd 0) is handled in the idle state. Add
// frame (cmd 1) runs a binary search over the sensor's sorted table, then
// moves every later entry up one slot through the single-port frame memory.
// Align (cmd 2) reads the reference frame, then for each other present
// sensor with a non-empty table runs a binary search plus two neighbor reads,
// and emits up to SENSORS-1 result words one per cycle while the output is
// not stalled.
// Frame storage is one memory of SENSORS*2**$clog2(MAX_FRAMES) words
// (timestamp and arrival index); entries are only read below a table's fill
// count, so no clearing pass is needed. One command is processed at a time;
// results sit in an output register so the next command is taken while a
// word waits.
module sensor_timestamp_aligner_core #(
  parameter int unsigned SENSORS    = 8,
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sta_pkg::in_word_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sta_pkg::out_word_t     out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [62:0]            cfg_wdata
);

  localparam int unsigned PW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned AW = SW + PW;
  localparam int unsigned DEPTH = SENSORS * (1 << PW);
  localparam int unsigned MW = sta_pkg::TS_W + sta_pkg::IDX_W;
  localparam int unsigned KW = $clog2(SENSORS + 1);

  // Frame memory: {timestamp, arrival index}.
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [MW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  logic [sta_pkg::TS_W-1:0]  rd_ts;
  logic [sta_pkg::IDX_W-1:0] rd_idx;
  assign rd_ts  = rdata_r[MW-1:sta_pkg::IDX_W];
  assign rd_idx = rdata_r[sta_pkg::IDX_W-1:0];

  // Per-sensor control state.
  logic [CW-1:0]            count_r [SENSORS];
  logic [sta_pkg::IDX_W-1:0] arrive_r [SENSORS];
  logic [SENSORS-1:0]       present_r;

  // Configuration.
  logic [62:0]              max_diff_r;
  logic                     req_all_r;
  logic [sta_pkg::SEN_W-1:0] main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_diff_r <= '0;
      req_all_r  <= 1'b0;
      main_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sta_pkg::REG_MAX_DIFF:    max_diff_r <= cfg_wdata;
        sta_pkg::REG_REQUIRE_ALL: req_all_r  <= cfg_wdata[0];
        sta_pkg::REG_MAIN_SENSOR: main_r     <= cfg_wdata[sta_pkg::SEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  sta_pkg::state_t state_r, state_nxt;
  sta_pkg::in_word_t cmd_r;
  logic [SW-1:0]  sen_r;
  logic [CW-1:0]  lo_r, hi_r, ptr_r;
  logic [CW-1:0]  mid;
  logic [sta_pkg::TS_W-1:0]  rts_r, hi_ts_r, lo_ts_r;
  logic [sta_pkg::IDX_W-1:0] ridx_r, hi_idx_r, lo_idx_r, new_idx_r;
  logic [SW:0]    scan_r;
  logic [KW-1:0]  others_r, k_r, emit_r;
  sta_pkg::out_word_t buf_r [SENSORS];
  sta_pkg::out_word_t out_r;
  logic           out_valid_r;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  logic           main_ok;
  logic           sen_ok;
  logic [SW-1:0]  in_sen;
  assign sen_ok  = ({2'b0, in_data.sensor} < 5'(SENSORS));
  assign main_ok = ({2'b0, main_r} < 5'(SENSORS));
  assign in_sen  = SW'(in_data.sensor);

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free &&
                    (state_r == sta_pkg::S_ADD_OUT || state_r == sta_pkg::S_AL_EMIT);
  assign in_ready = (state_r == sta_pkg::S_IDLE);

  // Scan position as an index.
  logic [SW-1:0] scan_idx;
  logic          scan_end;
  assign scan_idx = scan_r[SW-1:0];
  assign scan_end = (scan_r >= (SW+1)'(SENSORS));

  // Neighbor choice: earlier wins only when strictly closer.
  logic [sta_pkg::TS_W-1:0] d_hi, d_lo, d_best;
  logic use_lo, have_hi, have_lo, in_tol;
  assign have_hi = (lo_r < count_r[sen_r]);
  assign have_lo = (lo_r != '0);
  assign d_hi = (hi_ts_r >= rts_r) ? hi_ts_r - rts_r : rts_r - hi_ts_r;
  assign d_lo = (lo_ts_r >= rts_r) ? lo_ts_r - rts_r : rts_r - lo_ts_r;
  assign use_lo = have_lo && (!have_hi || (d_lo < d_hi));
  assign d_best = use_lo ? d_lo : d_hi;
  assign in_tol = (d_best <= max_diff_r);

  // Buffered match word with its last flag.
  sta_pkg::out_word_t emit_word;
  always_comb begin
    emit_word      = buf_r[emit_r[SW-1:0]];
    emit_word.last = (emit_r + 1'b1 == k_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sta_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == sta_pkg::CMD_ADD && sen_ok) begin
            if (!in_data.has_timestamp ||
                count_r[in_sen] >= CW'(MAX_FRAMES)) begin
              state_nxt = sta_pkg::S_ADD_OUT;
            end else begin
              state_nxt = sta_pkg::S_ADD_SRCH;
            end
          end else if (in_data.cmd == sta_pkg::CMD_ALIGN && main_ok) begin
            if (present_r[SW'(main_r)] &&
                32'(in_data.main_position) < 32'(count_r[SW'(main_r)])) begin
              state_nxt = sta_pkg::S_AL_RREF;
            end
          end
        end
      end
      sta_pkg::S_ADD_SRCH:
        state_nxt = (lo_r < hi_r) ? sta_pkg::S_ADD_SRD : sta_pkg::S_SHIFT_RD;
      sta_pkg::S_ADD_SRD:  state_nxt = sta_pkg::S_ADD_SRCH;
      sta_pkg::S_SHIFT_RD:
        state_nxt = (ptr_r > lo_r) ? sta_pkg::S_SHIFT_WR : sta_pkg::S_ADD_WR;
      sta_pkg::S_SHIFT_WR: state_nxt = sta_pkg::S_SHIFT_RD;
      sta_pkg::S_ADD_WR:   state_nxt = sta_pkg::S_ADD_OUT;
      sta_pkg::S_ADD_OUT:  state_nxt = out_free ? sta_pkg::S_IDLE : sta_pkg::S_ADD_OUT;
      sta_pkg::S_AL_RREF:  state_nxt = sta_pkg::S_AL_WREF;
      sta_pkg::S_AL_WREF:  state_nxt = sta_pkg::S_AL_NEXT;
      sta_pkg::S_AL_NEXT: begin
        if (scan_end) begin
          state_nxt = (k_r == '0 || (req_all_r && k_r != others_r)) ?
                      sta_pkg::S_IDLE : sta_pkg::S_AL_EMIT;
        end else if (scan_idx != SW'(main_r) && present_r[scan_idx] &&
                     count_r[scan_idx] != '0) begin
          state_nxt = sta_pkg::S_AL_SRCH;
        end
      end
      sta_pkg::S_AL_SRCH:
        state_nxt = (lo_r < hi_r) ? sta_pkg::S_AL_SRD : sta_pkg::S_AL_RHI;
      sta_pkg::S_AL_SRD:   state_nxt = sta_pkg::S_AL_SRCH;
      sta_pkg::S_AL_RHI:   state_nxt = sta_pkg::S_AL_WHI;
      sta_pkg::S_AL_WHI:   state_nxt = sta_pkg::S_AL_RLO;
      sta_pkg::S_AL_RLO:   state_nxt = sta_pkg::S_AL_WLO;
      sta_pkg::S_AL_WLO:   state_nxt = sta_pkg::S_AL_DEC;
      sta_pkg::S_AL_DEC:   state_nxt = sta_pkg::S_AL_NEXT;
      sta_pkg::S_AL_PUT:   state_nxt = sta_pkg::S_AL_NEXT;
      sta_pkg::S_AL_EMIT:
        state_nxt = (out_free && emit_r + 1'b1 == k_r) ? sta_pkg::S_IDLE :
                    sta_pkg::S_AL_EMIT;
      sta_pkg::S_EMIT_WAIT: state_nxt = sta_pkg::S_IDLE;
      default: state_nxt = sta_pkg::S_IDLE;
    endcase
  end

  // Memory port control. A moved entry is written straight from the read data.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {sen_r, PW'(mid)};
    mem_wdata = rdata_r;
    unique case (state_r)
      sta_pkg::S_SHIFT_RD: mem_addr = {sen_r, PW'(ptr_r - 1'b1)};
      sta_pkg::S_SHIFT_WR: begin
        mem_we   = 1'b1;
        mem_addr = {sen_r, PW'(ptr_r)};
      end
      sta_pkg::S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = {sen_r, PW'(lo_r)};
        mem_wdata = {cmd_r.timestamp, new_idx_r};
      end
      sta_pkg::S_AL_RREF:
        mem_addr = {SW'(main_r), PW'(cmd_r.main_position)};
      sta_pkg::S_AL_RHI: mem_addr = {sen_r, PW'(have_hi ? lo_r : lo_r - 1'b1)};
      sta_pkg::S_AL_RLO: mem_addr = {sen_r, PW'(have_lo ? lo_r - 1'b1 : lo_r)};
      default: ;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sta_pkg::S_IDLE;
      present_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        count_r[i]  <= '0;
        arrive_r[i] <= '0;
      end
      k_r      <= '0;
      others_r <= '0;
      emit_r   <= '0;
      scan_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        sta_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_data;
            sen_r <= in_sen;
            lo_r  <= '0;
            hi_r  <= count_r[in_sen];
            ptr_r <= count_r[in_sen];
            new_idx_r <= arrive_r[in_sen];
            k_r      <= '0;
            others_r <= '0;
            emit_r   <= '0;
            scan_r   <= '0;
            if (sen_ok && in_data.cmd == sta_pkg::CMD_OPEN) begin
              count_r[in_sen]   <= '0;
              arrive_r[in_sen]  <= '0;
              present_r[in_sen] <= 1'b1;
            end
            if (sen_ok && in_data.cmd == sta_pkg::CMD_ADD) begin
              arrive_r[in_sen]  <= arrive_r[in_sen] + 1'b1;
              present_r[in_sen] <= 1'b1;
            end
          end
        end
        sta_pkg::S_ADD_SRD: begin
          if (rd_ts <= cmd_r.timestamp) lo_r <= mid + 1'b1;
          else hi_r <= mid;
        end
        sta_pkg::S_SHIFT_RD: ;
        sta_pkg::S_SHIFT_WR: begin
          ptr_r  <= ptr_r - 1'b1;
        end
        sta_pkg::S_ADD_WR: count_r[sen_r] <= count_r[sen_r] + 1'b1;
        sta_pkg::S_ADD_OUT: begin
          if (out_free) begin
            out_r.status <= !cmd_r.has_timestamp ? sta_pkg::ST_SKIPPED :
                            (state_r == sta_pkg::S_ADD_OUT && ptr_r >= CW'(MAX_FRAMES) &&
                             lo_r == '0 && hi_r == ptr_r) ? sta_pkg::ST_FULL :
                            sta_pkg::ST_STORED;
            out_r.matched_sensor      <= cmd_r.sensor;
            out_r.reference_index     <= '0;
            out_r.reference_timestamp <= '0;
            out_r.matched_index       <= new_idx_r;
            out_r.matched_timestamp   <= cmd_r.has_timestamp ? cmd_r.timestamp : '0;
            out_r.ts_delta            <= '0;
            out_r.last                <= 1'b1;
          end
        end
        sta_pkg::S_AL_WREF: begin
          rts_r  <= rd_ts;
          ridx_r <= rd_idx;
        end
        sta_pkg::S_AL_NEXT: begin
          if (!scan_end) begin
            scan_r <= scan_r + 1'b1;
            sen_r  <= scan_idx;
            lo_r   <= '0;
            hi_r   <= count_r[scan_idx];
            if (scan_idx != SW'(main_r) && present_r[scan_idx]) begin
              others_r <= others_r + 1'b1;
            end
          end
        end
        sta_pkg::S_AL_SRD: begin
          if (rd_ts < rts_r) lo_r <= mid + 1'b1;
          else hi_r <= mid;
        end
        sta_pkg::S_AL_WHI: begin
          hi_ts_r  <= rd_ts;
          hi_idx_r <= rd_idx;
        end
        sta_pkg::S_AL_WLO: begin
          lo_ts_r  <= rd_ts;
          lo_idx_r <= rd_idx;
        end
        sta_pkg::S_AL_DEC: begin
          if (in_tol) begin
            buf_r[k_r[SW-1:0]].status <= sta_pkg::ST_MATCH;
            buf_r[k_r[SW-1:0]].matched_sensor <= sta_pkg::SEN_W'(sen_r);
            buf_r[k_r[SW-1:0]].reference_index <= ridx_r;
            buf_r[k_r[SW-1:0]].reference_timestamp <= rts_r;
            buf_r[k_r[SW-1:0]].matched_index <= use_lo ? lo_idx_r : hi_idx_r;
            buf_r[k_r[SW-1:0]].matched_timestamp <= use_lo ? lo_ts_r : hi_ts_r;
            buf_r[k_r[SW-1:0]].ts_delta <=
              {1'b0, (use_lo ? lo_ts_r : hi_ts_r)} - {1'b0, rts_r};
            buf_r[k_r[SW-1:0]].last <= 1'b0;
            k_r <= k_r + 1'b1;
          end
        end
        sta_pkg::S_AL_EMIT: begin
          if (out_free) begin
            out_r       <= emit_word;
            emit_r      <= emit_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `include "sensor_timestamp_aligner_core_assert.svh"

  `STA_ASSERT_IMP(a_ready_idle, in_ready, state_r == sta_pkg::S_IDLE, "ready outside idle")
  `STA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `STA_ASSERT_IMP(a_buf_bound, 1'b1, k_r <= KW'(SENSORS), "match count overflow")
  `STA_ASSERT_IMP(a_count_bound, state_r == sta_pkg::S_ADD_WR, count_r[sen_r] < CW'(MAX_FRAMES), "insert into full table")

endmodule

@@ sim/sensor_timestamp_aligner_checker.sv @@
`timescale 1ns / 100ps

// Watches the command, result and register channels of the aligner, keeps its own
// copy of the frame tables and compares every result word with the predicted one.
module sensor_timestamp_aligner_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sta_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sta_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [62:0]        cfg_wdata,
  output int                 errors,
  output int                 pending,
  output int                 words_checked,
  output int                 matches_seen
);

  localparam int NSEN = 8;
  localparam int NFRM = 4096;

  // Shadow copy of the frame tables and register file.
  logic [sta_pkg::TS_W-1:0]  frame_ts   [NSEN][NFRM];
  logic [sta_pkg::IDX_W-1:0] frame_org  [NSEN][NFRM];
  int unsigned               fill_cnt   [NSEN];
  logic [sta_pkg::IDX_W-1:0] arrival    [NSEN];
  bit                        present    [NSEN];
  logic [62:0]               tol;
  logic                      need_all;
  logic [2:0]                ref_sensor;

  sta_pkg::out_word_t expected_words[$];

  function automatic logic [62:0] distance(logic [62:0] a, logic [62:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Nearest entry of one table; the earlier neighbor wins only when strictly closer.
  function automatic bit find_nearest(int s, logic [62:0] t, output int slot);
    int lo, hi, mid, n;
    n = fill_cnt[s];
    lo = 0;
    hi = n;
    slot = 0;
    if (n == 0) return 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (frame_ts[s][mid] < t) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n) begin
      slot = lo;
      if (lo > 0 && distance(frame_ts[s][lo-1], t) < distance(frame_ts[s][lo], t))
        slot = lo - 1;
    end else begin
      slot = n - 1;
    end
    return distance(frame_ts[s][slot], t) <= tol;
  endfunction

  // Applies one accepted command word and queues the words it should produce.
  task automatic apply_command(sta_pkg::in_word_t w);
    sta_pkg::out_word_t r;
    sta_pkg::out_word_t grp[$];
    int s, n, lo, hi, mid, slot, others;
    logic [sta_pkg::IDX_W-1:0] idx;
    logic [62:0] rts;
    logic [sta_pkg::IDX_W-1:0] ridx;
    r = '0;
    s = w.sensor;
    if (w.cmd == sta_pkg::CMD_OPEN) begin
      fill_cnt[s] = 0;
      arrival[s] = '0;
      present[s] = 1'b1;
    end else if (w.cmd == sta_pkg::CMD_ADD) begin
      idx = arrival[s];
      arrival[s] = idx + 1'b1;
      present[s] = 1'b1;
      n = fill_cnt[s];
      r.matched_sensor = w.sensor;
      r.matched_index = idx;
      r.last = 1'b1;
      if (!w.has_timestamp) begin
        r.status = sta_pkg::ST_SKIPPED;
      end else if (n >= NFRM) begin
        r.status = sta_pkg::ST_FULL;
        r.matched_timestamp = w.timestamp;
      end else begin
        lo = 0;
        hi = n;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (frame_ts[s][mid] <= w.timestamp) lo = mid + 1;
          else hi = mid;
        end
        for (int j = n; j > lo; j--) begin
          frame_ts[s][j] = frame_ts[s][j-1];
          frame_org[s][j] = frame_org[s][j-1];
        end
        frame_ts[s][lo] = w.timestamp;
        frame_org[s][lo] = idx;
        fill_cnt[s] = n + 1;
        r.status = sta_pkg::ST_STORED;
        r.matched_timestamp = w.timestamp;
      end
      expected_words = {expected_words, r};
    end else if (w.cmd == sta_pkg::CMD_ALIGN) begin
      if (present[ref_sensor] && w.main_position < fill_cnt[ref_sensor]) begin
        rts = frame_ts[ref_sensor][w.main_position];
        ridx = frame_org[ref_sensor][w.main_position];
        others = 0;
        for (int k = 0; k < NSEN; k++) begin
          if (k != ref_sensor && present[k]) begin
            others++;
            if (find_nearest(k, rts, slot)) begin
              r = '0;
              r.status = sta_pkg::ST_MATCH;
              r.matched_sensor = k[2:0];
              r.reference_index = ridx;
              r.reference_timestamp = rts;
              r.matched_index = frame_org[k][slot];
              r.matched_timestamp = frame_ts[k][slot];
              r.ts_delta = {1'b0, frame_ts[k][slot]} - {1'b0, rts};
              grp = {grp, r};
            end
          end
        end
        if (grp.size() != 0 && !(need_all && grp.size() != others)) begin
          grp[grp.size()-1].last = 1'b1;
          foreach (grp[i]) expected_words = {expected_words, grp[i]};
          matches_seen += grp.size();
        end
      end
    end
  endtask

  // Field-by-field comparison against the oldest expected word.
  task automatic compare_word(sta_pkg::out_word_t got);
    sta_pkg::out_word_t exp_w;
    if (expected_words.size() == 0) begin
      $error("result word with no expected word waiting");
      errors++;
      return;
    end
    exp_w = expected_words.pop_front();
    words_checked++;
    if (got.status !== exp_w.status) begin
      $error("status: expected %0d, got %0d", exp_w.status, got.status);
      errors++;
    end
    if (got.matched_sensor !== exp_w.matched_sensor) begin
      $error("matched_sensor: expected %0d, got %0d", exp_w.matched_sensor,
             got.matched_sensor);
      errors++;
    end
    if (got.reference_index !== exp_w.reference_index) begin
      $error("reference_index: expected %0d, got %0d", exp_w.reference_index,
             got.reference_index);
      errors++;
    end
    if (got.reference_timestamp !== exp_w.reference_timestamp) begin
      $error("reference_timestamp: expected %0d, got %0d", exp_w.reference_timestamp,
             got.reference_timestamp);
      errors++;
    end
    if (got.matched_index !== exp_w.matched_index) begin
      $error("matched_index: expected %0d, got %0d", exp_w.matched_index,
             got.matched_index);
      errors++;
    end
    if (got.matched_timestamp !== exp_w.matched_timestamp) begin
      $error("matched_timestamp: expected %0d, got %0d", exp_w.matched_timestamp,
             got.matched_timestamp);
      errors++;
    end
    if (got.ts_delta !== exp_w.ts_delta) begin
      $error("ts_delta: expected %0d, got %0d", exp_w.ts_delta, got.ts_delta);
      errors++;
    end
    if (got.last !== exp_w.last) begin
      $error("last: expected %0d, got %0d", exp_w.last, got.last);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    words_checked = 0;
    matches_seen = 0;
  end

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSEN; k++) begin
        fill_cnt[k] = 0;
        arrival[k] = '0;
        present[k] = 1'b0;
      end
      tol = '0;
      need_all = 1'b0;
      ref_sensor = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) compare_word(out_data);
      if (cfg_we) begin
        case (cfg_index)
          sta_pkg::REG_MAX_DIFF: tol = cfg_wdata;
          sta_pkg::REG_REQUIRE_ALL: need_all = cfg_wdata[0];
          sta_pkg::REG_MAIN_SENSOR: ref_sensor = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) apply_command(in_data);
    end
    pending = expected_words.size();
  end

endmodule

@@ sim/sensor_timestamp_aligner_core_tb.sv @@
`timescale 1ns / 100ps

module sensor_timestamp_aligner_core_tb;

  // Command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [62:0] TS_MAX = {63{1'b1}};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sta_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sta_pkg::out_word_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [62:0] cfg_wdata;

  int errors;
  int pending;
  int words_checked;
  int matches_seen;
  int words_sent;

  bit idle_on;
  bit hold_go;
  int hold_left;
  int gap_left;

  sensor_timestamp_aligner_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sensor_timestamp_aligner_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending),
    .words_checked(words_checked), .matches_seen(matches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (!idle_on) begin
        out_ready = 1'b1;
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic [62:0] rand_ts();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic sta_pkg::in_word_t make_word(logic [1:0] cmd, logic [2:0] sen,
                                                  logic has_ts, logic [62:0] ts,
                                                  logic [11:0] pos);
    sta_pkg::in_word_t w;
    w.cmd = cmd;
    w.sensor = sen;
    w.has_timestamp = has_ts;
    w.timestamp = ts;
    w.main_position = pos;
    return w;
  endfunction

  // Offers one word and returns once it is accepted; valid stays up afterward.
  task automatic send(sta_pkg::in_word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Register writes happen only once the block has drained and settled.
  task automatic write_reg(logic [1:0] idx, logic [62:0] val);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add(logic [2:0] sen, logic [62:0] ts);
    send(make_word(sta_pkg::CMD_ADD, sen, 1'b1, ts, '0));
  endtask

  task automatic align(logic [11:0] pos);
    send(make_word(sta_pkg::CMD_ALIGN, 3'($urandom), 1'($urandom), rand_ts(), pos));
  endtask

  // One random word, mostly well-formed traffic around a common time base.
  task automatic random_word(logic [62:0] base);
    int pick;
    logic [62:0] ts;
    logic [2:0] sen;
    pick = $urandom_range(0, 99);
    sen = 3'($urandom_range(0, 5));
    ts = ($urandom_range(0, 9) == 0) ? rand_ts() : base + 63'($urandom_range(0, 20000));
    if (pick < 4) begin
      send(make_word(sta_pkg::CMD_OPEN, sen, 1'($urandom), rand_ts(), 12'($urandom)));
    end else if (pick < 8) begin
      send(make_word(CMD_UNUSED, 3'($urandom), 1'($urandom), rand_ts(), 12'($urandom)));
    end else if (pick < 12) begin
      send(make_word(sta_pkg::CMD_ADD, 3'($urandom), 1'b0, rand_ts(), 12'($urandom)));
    end else if (pick < 60) begin
      send(make_word(sta_pkg::CMD_ADD, sen, 1'b1, ts, 12'($urandom)));
    end else if (pick < 95) begin
      align(12'($urandom_range(0, 20)));
    end else begin
      align(12'($urandom));
    end
  endtask

  initial begin
    logic [62:0] base;
    logic [62:0] tol_pick [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = sta_pkg::REG_MAX_DIFF;
    cfg_wdata = '0;
    idle_on = 1'b1;
    hold_go = 1'b0;
    words_sent = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: ties, equal keys, empty tables, extremes and ignored commands.
    write_reg(sta_pkg::REG_MAX_DIFF, 63'd100);
    write_reg(sta_pkg::REG_REQUIRE_ALL, 63'd0);
    write_reg(sta_pkg::REG_MAIN_SENSOR, 63'd0);
    align(12'd0);
    send(make_word(sta_pkg::CMD_OPEN, 3'd0, 1'b1, TS_MAX, 12'hFFF));
    add(3'd0, 63'd1000);
    add(3'd0, 63'd2000);
    add(3'd1, 63'd990);
    add(3'd1, 63'd1010);
    add(3'd1, 63'd1010);
    send(make_word(sta_pkg::CMD_ADD, 3'd2, 1'b0, TS_MAX, 12'hFFF));
    add(3'd3, TS_MAX);
    add(3'd3, 63'd0);
    align(12'd0);
    align(12'd1);
    align(12'd2);
    align(12'hFFF);
    send(make_word(CMD_UNUSED, 3'd7, 1'b1, TS_MAX, 12'hFFF));
    write_reg(sta_pkg::REG_MAX_DIFF, TS_MAX);
    align(12'd0);
    write_reg(sta_pkg::REG_REQUIRE_ALL, 63'd1);
    align(12'd0);
    send(make_word(sta_pkg::CMD_OPEN, 3'd2, 1'b0, 63'd0, 12'd0));
    add(3'd2, 63'd1500);
    align(12'd1);
    write_reg(sta_pkg::REG_MAIN_SENSOR, 63'd5);
    align(12'd0);
    write_reg(sta_pkg::REG_MAX_DIFF, 63'd0);
    write_reg(sta_pkg::REG_MAIN_SENSOR, 63'd1);
    align(12'd1);

    // Random phases over several register settings.
    tol_pick[0] = 63'd0;
    tol_pick[1] = 63'd2000;
    tol_pick[2] = 63'd8000;
    tol_pick[3] = TS_MAX;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(sta_pkg::REG_MAX_DIFF, tol_pick[ph]);
      write_reg(sta_pkg::REG_REQUIRE_ALL, 63'(ph[0]));
      write_reg(sta_pkg::REG_MAIN_SENSOR, (ph == 3) ? 63'd7 : 63'($urandom_range(0, 5)));
      base = rand_ts() >> $urandom_range(0, 8);
      for (int i = 0; i < 70; i++) begin
        if (ph == 1 && i == 20) hold_go = 1'b1;
        if (ph == 2 && i == 45) begin
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
        random_word(base);
      end
    end

    // Final part without idling on either side.
    write_reg(sta_pkg::REG_MAIN_SENSOR, 63'd1);
    idle_on = 1'b0;
    for (int i = 0; i < 50; i++) random_word(base);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d command words; checked %0d result words, %0d of them matches.",
             words_sent, words_checked, matches_seen);
    $display("Covered ties, equal keys, empty tables, tolerance, require-all and stalls.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sta_pkg.sv
design/sensor_timestamp_aligner_core.sv
sim/sensor_timestamp_aligner_checker.sv
sim/sensor_timestamp_aligner_core_tb.sv
